// File: sv/svf_pkg.sv
package svf_pkg;

  localparam int CHANNELS = 2;
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int SAMPLE_W = 24;
  localparam int STATE_W = 32;
  localparam int COEF_W = 31;
  localparam int MODE_W = 4;
  localparam int FRAC_W = 28;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = COEF_W;

  localparam int P_W = 40;
  localparam int Q_W = 34;
  localparam int R_W = 46;
  localparam int A2Q_W = 36;
  localparam int ACC_W = 48;
  localparam int HALF_W = (P_W + 1) / 2;
  localparam int PROD_W = P_W + Q_W + 1;

  typedef logic signed [SAMPLE_W-1:0] smp_t;
  typedef logic signed [STATE_W-1:0] st_t;
  typedef logic [COEF_W-1:0] coef_t;
  typedef logic signed [P_W-1:0] pop_t;
  typedef logic signed [Q_W-1:0] qop_t;
  typedef logic signed [R_W-1:0] res_t;
  typedef logic signed [A2Q_W-1:0] a2q_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam pop_t ONE_P = pop_t'(1) <<< FRAC_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_A1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_A2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_A3 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_K = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_SHELF = CFG_IDX_W'(5);

  localparam logic [MODE_W-1:0] MODE_LP = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_BP = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_NOTCH = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_HP = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_AP = MODE_W'(4);
  localparam logic [MODE_W-1:0] MODE_PEAK = MODE_W'(5);
  localparam logic [MODE_W-1:0] MODE_BELL = MODE_W'(6);
  localparam logic [MODE_W-1:0] MODE_LSHELF = MODE_W'(7);
  localparam logic [MODE_W-1:0] MODE_HSHELF = MODE_W'(8);

  localparam coef_t A1_RST = coef_t'(1) << FRAC_W;
  localparam coef_t K_RST = coef_t'(2) << FRAC_W;
  localparam coef_t SHELF_RST = coef_t'(1) << FRAC_W;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_V3,
    OP_V1,
    OP_V2,
    OP_STORE,
    OP_PRESET,
    OP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    P_A1,
    P_A2,
    P_A3,
    P_K,
    P_K2,
    P_SHELF,
    P_A2M1,
    P_AM1,
    P_OMA,
    P_T,
    P_A2Q,
    P_OMA2
  } p_sel_t;

  typedef enum logic [2:0] {
    Q_IC1,
    Q_V3,
    Q_V1,
    Q_V2,
    Q_V0,
    Q_SHELF,
    Q_K
  } q_sel_t;

  typedef enum logic [1:0] {
    D_ADD,
    D_SUB,
    D_T,
    D_A2
  } dst_t;

  typedef struct packed {
    logic load;
    dp_op_t op;
    logic mul_go;
    p_sel_t p_sel;
    q_sel_t q_sel;
    dst_t dst;
  } svf_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic mul_busy;
    logic out_free;
    logic [MODE_W-1:0] mode;
  } svf_stat_t;

endpackage

// File: sv/svf_in_if.sv
interface svf_in_if;
  logic valid;
  logic ready;
  logic channel;
  logic signed [svf_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink (input valid, input channel, input sample_in, output ready);
endinterface

// File: sv/svf_out_if.sv
interface svf_out_if;
  logic valid;
  logic ready;
  logic channel_out;
  logic signed [svf_pkg::SAMPLE_W-1:0] sample_out;

  modport source (output valid, output channel_out, output sample_out, input ready);
  modport sink (input valid, input channel_out, input sample_out, output ready);
endinterface

// File: sv/svf_mul.sv
module svf_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  svf_pkg::pop_t     p,
  input  svf_pkg::qop_t     q,
  output logic              busy,
  output logic              done,
  output svf_pkg::res_t     res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LO,
    PH_HI,
    PH_RND
  } ph_t;

  ph_t                                  ph_r;
  logic [svf_pkg::P_W-1:0]              pm_r;
  logic [svf_pkg::Q_W-1:0]              qm_r;
  logic                                 neg_r;
  logic [svf_pkg::PROD_W-1:0]           prod_r;
  logic                                 done_r;
  svf_pkg::res_t                        res_r;
  logic [svf_pkg::P_W-1:0]              p_mag;
  logic [svf_pkg::Q_W-1:0]              q_mag;
  logic [svf_pkg::HALF_W-1:0]           mul_a;
  logic [svf_pkg::HALF_W+svf_pkg::Q_W-1:0] pp;
  logic [svf_pkg::R_W-2:0]              mag;

  assign p_mag = p[svf_pkg::P_W-1] ? unsigned'(-p) : unsigned'(p);
  assign q_mag = q[svf_pkg::Q_W-1] ? unsigned'(-q) : unsigned'(q);

  assign mul_a = (ph_r == PH_LO) ? pm_r[svf_pkg::HALF_W-1:0]
               : svf_pkg::HALF_W'(pm_r[svf_pkg::P_W-1:svf_pkg::HALF_W]);
  assign pp = mul_a * qm_r;
  assign mag = prod_r[svf_pkg::FRAC_W +: svf_pkg::R_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= (ph_r == PH_RND);
      unique case (ph_r)
        PH_IDLE: begin
          if (go) begin
            pm_r <= p_mag;
            qm_r <= q_mag;
            neg_r <= p[svf_pkg::P_W-1] ^ q[svf_pkg::Q_W-1];
            ph_r <= PH_LO;
          end
        end
        PH_LO: begin
          prod_r <= svf_pkg::PROD_W'(pp)
                  + (svf_pkg::PROD_W'(1) << (svf_pkg::FRAC_W - 1));
          ph_r <= PH_HI;
        end
        PH_HI: begin
          prod_r <= prod_r + (svf_pkg::PROD_W'(pp) << svf_pkg::HALF_W);
          ph_r <= PH_RND;
        end
        PH_RND: begin
          res_r <= neg_r ? -svf_pkg::res_t'(mag) : svf_pkg::res_t'(mag);
          ph_r <= PH_IDLE;
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  assign busy = (ph_r != PH_IDLE);
  assign done = done_r;
  assign res = res_r;

`ifndef SYNTHESIS
  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> (ph_r == PH_IDLE))
    else $error("Product started while the multiplier was busy.");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("Product completion lasted more than one cycle.");
`endif

endmodule

// File: sv/svf_dp.sv
module svf_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  svf_pkg::svf_cmd_t                cmd,
  output svf_pkg::svf_stat_t               stat,
  input  logic                             in_channel,
  input  svf_pkg::smp_t                    in_sample,
  input  logic                             cfg_we,
  input  logic [svf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             out_channel,
  output svf_pkg::smp_t                    out_sample
);

  function automatic svf_pkg::st_t sat_state(input svf_pkg::acc_t x);
    svf_pkg::st_t y;
    if (x[svf_pkg::ACC_W-1:svf_pkg::STATE_W-1] == '0 ||
        x[svf_pkg::ACC_W-1:svf_pkg::STATE_W-1] == '1) begin
      y = svf_pkg::st_t'(x);
    end else if (x[svf_pkg::ACC_W-1]) begin
      y = {1'b1, {(svf_pkg::STATE_W-1){1'b0}}};
    end else begin
      y = {1'b0, {(svf_pkg::STATE_W-1){1'b1}}};
    end
    return y;
  endfunction

  function automatic svf_pkg::smp_t sat_sample(input svf_pkg::acc_t x);
    svf_pkg::smp_t y;
    if (x[svf_pkg::ACC_W-1:svf_pkg::SAMPLE_W-1] == '0 ||
        x[svf_pkg::ACC_W-1:svf_pkg::SAMPLE_W-1] == '1) begin
      y = svf_pkg::smp_t'(x);
    end else if (x[svf_pkg::ACC_W-1]) begin
      y = {1'b1, {(svf_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      y = {1'b0, {(svf_pkg::SAMPLE_W-1){1'b1}}};
    end
    return y;
  endfunction

  logic [svf_pkg::MODE_W-1:0] mode_r;
  svf_pkg::coef_t             a1_r;
  svf_pkg::coef_t             a2_r;
  svf_pkg::coef_t             a3_r;
  svf_pkg::coef_t             k_r;
  svf_pkg::coef_t             shelf_r;

  svf_pkg::st_t               int_one_r [svf_pkg::CHANNELS];
  svf_pkg::st_t               int_two_r [svf_pkg::CHANNELS];

  logic                       ch_r;
  logic [svf_pkg::IDX_W-1:0]  idx_r;
  svf_pkg::smp_t              v0_r;
  svf_pkg::st_t               ic1_r;
  svf_pkg::st_t               ic2_r;
  svf_pkg::st_t               v3_r;
  svf_pkg::st_t               v1_r;
  svf_pkg::st_t               v2_r;
  svf_pkg::acc_t              acc_r;
  svf_pkg::pop_t              t_r;
  svf_pkg::a2q_t              a2q_r;
  svf_pkg::dst_t              dst_r;

  logic                       out_valid_r;
  logic                       out_channel_r;
  svf_pkg::smp_t              out_sample_r;

  logic [svf_pkg::IDX_W-1:0]  in_idx;
  svf_pkg::pop_t              p_op;
  svf_pkg::qop_t              q_op;
  svf_pkg::acc_t              preset;
  logic                       mul_busy;
  logic                       mul_done;
  svf_pkg::res_t              mul_res;

  assign in_idx = (svf_pkg::CHANNELS > 1) ? svf_pkg::IDX_W'(in_channel) : '0;

  always_comb begin
    case (cmd.p_sel)
      svf_pkg::P_A1:    p_op = svf_pkg::pop_t'(a1_r);
      svf_pkg::P_A2:    p_op = svf_pkg::pop_t'(a2_r);
      svf_pkg::P_A3:    p_op = svf_pkg::pop_t'(a3_r);
      svf_pkg::P_K:     p_op = svf_pkg::pop_t'(k_r);
      svf_pkg::P_K2:    p_op = svf_pkg::pop_t'({k_r, 1'b0});
      svf_pkg::P_SHELF: p_op = svf_pkg::pop_t'(shelf_r);
      svf_pkg::P_A2M1:  p_op = svf_pkg::pop_t'(a2q_r) - svf_pkg::ONE_P;
      svf_pkg::P_AM1:   p_op = svf_pkg::pop_t'(shelf_r) - svf_pkg::ONE_P;
      svf_pkg::P_OMA:   p_op = svf_pkg::ONE_P - svf_pkg::pop_t'(shelf_r);
      svf_pkg::P_T:     p_op = t_r;
      svf_pkg::P_A2Q:   p_op = svf_pkg::pop_t'(a2q_r);
      svf_pkg::P_OMA2:  p_op = svf_pkg::ONE_P - svf_pkg::pop_t'(a2q_r);
      default:          p_op = '0;
    endcase
  end

  always_comb begin
    case (cmd.q_sel)
      svf_pkg::Q_IC1:   q_op = svf_pkg::qop_t'(ic1_r);
      svf_pkg::Q_V3:    q_op = svf_pkg::qop_t'(v3_r);
      svf_pkg::Q_V1:    q_op = svf_pkg::qop_t'(v1_r);
      svf_pkg::Q_V2:    q_op = svf_pkg::qop_t'(v2_r);
      svf_pkg::Q_V0:    q_op = svf_pkg::qop_t'(v0_r);
      svf_pkg::Q_SHELF: q_op = svf_pkg::qop_t'(shelf_r);
      svf_pkg::Q_K:     q_op = svf_pkg::qop_t'(k_r);
      default:          q_op = '0;
    endcase
  end

  always_comb begin
    unique case (mode_r) inside
      svf_pkg::MODE_LP: preset = svf_pkg::acc_t'(v2_r);
      svf_pkg::MODE_BP: preset = svf_pkg::acc_t'(v1_r);
      svf_pkg::MODE_NOTCH, svf_pkg::MODE_AP, svf_pkg::MODE_BELL, svf_pkg::MODE_LSHELF:
        preset = svf_pkg::acc_t'(v0_r);
      svf_pkg::MODE_HP: preset = svf_pkg::acc_t'(v0_r) - svf_pkg::acc_t'(v2_r);
      svf_pkg::MODE_PEAK:
        preset = (svf_pkg::acc_t'(v2_r) <<< 1) - svf_pkg::acc_t'(v0_r);
      default: preset = '0;
    endcase
  end

  svf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.mul_go),
    .p     (p_op),
    .q     (q_op),
    .busy  (mul_busy),
    .done  (mul_done),
    .res   (mul_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= svf_pkg::MODE_LP;
      a1_r <= svf_pkg::A1_RST;
      a2_r <= '0;
      a3_r <= '0;
      k_r <= svf_pkg::K_RST;
      shelf_r <= svf_pkg::SHELF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        svf_pkg::CFG_MODE:  mode_r <= cfg_wdata[svf_pkg::MODE_W-1:0];
        svf_pkg::CFG_A1:    a1_r <= cfg_wdata;
        svf_pkg::CFG_A2:    a2_r <= cfg_wdata;
        svf_pkg::CFG_A3:    a3_r <= cfg_wdata;
        svf_pkg::CFG_K:     k_r <= cfg_wdata;
        svf_pkg::CFG_SHELF: shelf_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < svf_pkg::CHANNELS; i++) begin
        int_one_r[i] <= '0;
        int_two_r[i] <= '0;
      end
    end else if (cmd.op == svf_pkg::OP_STORE) begin
      int_one_r[idx_r] <= sat_state((svf_pkg::acc_t'(v1_r) <<< 1) - svf_pkg::acc_t'(ic1_r));
      int_two_r[idx_r] <= sat_state((svf_pkg::acc_t'(v2_r) <<< 1) - svf_pkg::acc_t'(ic2_r));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r <= in_channel;
      idx_r <= in_idx;
      v0_r <= in_sample;
      ic1_r <= int_one_r[in_idx];
      ic2_r <= int_two_r[in_idx];
    end
    if (cmd.mul_go) begin
      dst_r <= cmd.dst;
    end
    case (cmd.op)
      svf_pkg::OP_V3: begin
        v3_r <= sat_state(svf_pkg::acc_t'(v0_r) - svf_pkg::acc_t'(ic2_r));
        acc_r <= '0;
      end
      svf_pkg::OP_V1: begin
        v1_r <= sat_state(acc_r);
        acc_r <= svf_pkg::acc_t'(ic2_r);
      end
      svf_pkg::OP_V2: v2_r <= sat_state(acc_r);
      svf_pkg::OP_PRESET: acc_r <= preset;
      default: ;
    endcase
    if (mul_done) begin
      case (dst_r)
        svf_pkg::D_ADD: acc_r <= acc_r + svf_pkg::acc_t'(mul_res);
        svf_pkg::D_SUB: acc_r <= acc_r - svf_pkg::acc_t'(mul_res);
        svf_pkg::D_T:   t_r <= svf_pkg::pop_t'(mul_res);
        svf_pkg::D_A2:  a2q_r <= svf_pkg::a2q_t'(mul_res);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == svf_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
        out_channel_r <= ch_r;
        out_sample_r <= sat_sample(acc_r);
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_sample = out_sample_r;

  assign stat.mul_done = mul_done;
  assign stat.mul_busy = mul_busy;
  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.mode = mode_r;

`ifndef SYNTHESIS
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == svf_pkg::OP_OUT) |-> (!out_valid_r || out_ready))
    else $error("Result written over an item still waiting on the output.");
`endif

endmodule

// File: sv/svf_ctrl.sv
module svf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  svf_pkg::svf_stat_t  stat,
  output svf_pkg::svf_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_V3,
    S_BAND,
    S_V1,
    S_LOW,
    S_V2,
    S_STORE,
    S_PRESET,
    S_MIX,
    S_OUT
  } state_t;

  typedef struct packed {
    svf_pkg::p_sel_t p_sel;
    svf_pkg::q_sel_t q_sel;
    svf_pkg::dst_t   dst;
    logic            last;
  } mstep_t;

  function automatic mstep_t mul_step(input state_t st,
                                      input logic [svf_pkg::MODE_W-1:0] mode,
                                      input logic [2:0] step);
    mstep_t m;
    m.p_sel = svf_pkg::P_A1;
    m.q_sel = svf_pkg::Q_IC1;
    m.dst = svf_pkg::D_ADD;
    m.last = 1'b1;
    if (st == S_BAND) begin
      if (step == 3'd0) begin
        m.last = 1'b0;
      end else begin
        m.p_sel = svf_pkg::P_A2;
        m.q_sel = svf_pkg::Q_V3;
      end
    end else if (st == S_LOW) begin
      if (step == 3'd0) begin
        m.p_sel = svf_pkg::P_A2;
        m.last = 1'b0;
      end else begin
        m.p_sel = svf_pkg::P_A3;
        m.q_sel = svf_pkg::Q_V3;
      end
    end else begin
      unique case (mode) inside
        svf_pkg::MODE_NOTCH, svf_pkg::MODE_HP: begin
          m.p_sel = svf_pkg::P_K;
          m.q_sel = svf_pkg::Q_V1;
          m.dst = svf_pkg::D_SUB;
        end
        svf_pkg::MODE_AP: begin
          m.p_sel = svf_pkg::P_K2;
          m.q_sel = svf_pkg::Q_V1;
          m.dst = svf_pkg::D_SUB;
        end
        svf_pkg::MODE_PEAK: begin
          m.p_sel = svf_pkg::P_K;
          m.q_sel = svf_pkg::Q_V1;
        end
        svf_pkg::MODE_BELL, svf_pkg::MODE_LSHELF, svf_pkg::MODE_HSHELF: begin
          m.last = 1'b0;
          case (step)
            3'd0: begin
              m.p_sel = svf_pkg::P_SHELF;
              m.q_sel = svf_pkg::Q_SHELF;
              m.dst = svf_pkg::D_A2;
            end
            3'd1: begin
              m.p_sel = (mode == svf_pkg::MODE_BELL) ? svf_pkg::P_A2M1
                      : (mode == svf_pkg::MODE_LSHELF) ? svf_pkg::P_AM1 : svf_pkg::P_OMA;
              m.q_sel = svf_pkg::Q_K;
              m.dst = svf_pkg::D_T;
            end
            3'd2: begin
              if (mode == svf_pkg::MODE_HSHELF) begin
                m.p_sel = svf_pkg::P_T;
                m.q_sel = svf_pkg::Q_SHELF;
                m.dst = svf_pkg::D_T;
              end else begin
                m.p_sel = svf_pkg::P_T;
                m.q_sel = svf_pkg::Q_V1;
                m.last = (mode == svf_pkg::MODE_BELL);
              end
            end
            3'd3: begin
              if (mode == svf_pkg::MODE_HSHELF) begin
                m.p_sel = svf_pkg::P_A2Q;
                m.q_sel = svf_pkg::Q_V0;
              end else begin
                m.p_sel = svf_pkg::P_A2M1;
                m.q_sel = svf_pkg::Q_V2;
                m.last = 1'b1;
              end
            end
            3'd4: begin
              m.p_sel = svf_pkg::P_T;
              m.q_sel = svf_pkg::Q_V1;
            end
            default: begin
              m.p_sel = svf_pkg::P_OMA2;
              m.q_sel = svf_pkg::Q_V2;
              m.last = 1'b1;
            end
          endcase
        end
        default: ;
      endcase
    end
    return m;
  endfunction

  state_t     state_r;
  logic [2:0] step_r;
  logic       issued_r;
  mstep_t     ms;
  logic       has_mix;

  assign ms = mul_step(state_r, stat.mode, step_r);
  assign has_mix = (stat.mode >= svf_pkg::MODE_NOTCH) && (stat.mode <= svf_pkg::MODE_HSHELF);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd.load = (state_r == S_IDLE) && in_valid;
    cmd.op = svf_pkg::OP_NONE;
    cmd.mul_go = 1'b0;
    cmd.p_sel = ms.p_sel;
    cmd.q_sel = ms.q_sel;
    cmd.dst = ms.dst;
    unique case (state_r)
      S_IDLE: ;
      S_V3: cmd.op = svf_pkg::OP_V3;
      S_V1: cmd.op = svf_pkg::OP_V1;
      S_V2: cmd.op = svf_pkg::OP_V2;
      S_STORE: cmd.op = svf_pkg::OP_STORE;
      S_PRESET: cmd.op = svf_pkg::OP_PRESET;
      S_OUT: cmd.op = stat.out_free ? svf_pkg::OP_OUT : svf_pkg::OP_NONE;
      S_BAND, S_LOW, S_MIX: cmd.mul_go = !issued_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= '0;
      issued_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_V3;
          end
        end
        S_V3: begin
          step_r <= '0;
          state_r <= S_BAND;
        end
        S_BAND, S_LOW, S_MIX: begin
          if (!issued_r) begin
            issued_r <= 1'b1;
          end else if (stat.mul_done) begin
            issued_r <= 1'b0;
            if (ms.last) begin
              step_r <= '0;
              state_r <= (state_r == S_BAND) ? S_V1 : (state_r == S_LOW) ? S_V2 : S_OUT;
            end else begin
              step_r <= step_r + 3'd1;
            end
          end
        end
        S_V1: state_r <= S_LOW;
        S_V2: state_r <= S_STORE;
        S_STORE: state_r <= S_PRESET;
        S_PRESET: state_r <= has_mix ? S_MIX : S_OUT;
        S_OUT: begin
          if (stat.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_outstanding: assert property (@(posedge clk) disable iff (!rst_n)
    stat.mul_done |-> issued_r)
    else $error("Product completed with none outstanding.");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !stat.mul_busy)
    else $error("Multiplier busy while waiting for an item.");
`endif

endmodule

// File: sv/trapezoidal_state_variable_filter.sv
// Port      Role    Carries
// in_bus    sink    channel, sample_in
// out_bus   source  channel_out, sample_out
// cfg_*     write   0 mode, 1 a1, 2 a2, 3 a3, 4 damping k, 5 shelf gain
//
// The time from one acceptance to the next grows with n, the number of mixing products
// of the mode: 0 for lowpass and bandpass, 1 for notch, highpass, allpass and peak,
// 3 for bell, 4 for low shelf and 6 for high shelf. The pace is set by the one shared
// multiplier, which also serves the four products of the filter core. Reset loads the
// register defaults and clears the integrators at once. A result waiting on out_bus
// holds the following item only in its output state.
module trapezoidal_state_variable_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  svf_in_if.sink                          in_bus,
  svf_out_if.source                       out_bus,
  input  logic                            cfg_we,
  input  logic [svf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [svf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  svf_pkg::svf_cmd_t  cmd;
  svf_pkg::svf_stat_t stat;

  svf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  svf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_channel  (in_bus.channel),
    .in_sample   (in_bus.sample_in),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .out_ready   (out_bus.ready),
    .out_valid   (out_bus.valid),
    .out_channel (out_bus.channel_out),
    .out_sample  (out_bus.sample_out)
  );

endmodule

// File: tb/trapezoidal_state_variable_filter_tb.sv
`timescale 1ns / 100ps

import svf_pkg::*;

function automatic longint clip_to(longint x, int bits);
  longint hi;
  longint lo;
  hi = (longint'(1) <<< (bits - 1)) - 1;
  lo = -hi - 1;
  if (x > hi) return hi;
  if (x < lo) return lo;
  return x;
endfunction

// Q.28 product, rounded to nearest with ties away from zero.
function automatic longint q28_mul(longint a, longint b);
  logic [127:0] am;
  logic [127:0] bm;
  logic [127:0] p;
  bit neg;
  a = clip_to(a, 41);
  b = clip_to(b, 37);
  neg = (a < 0) != (b < 0);
  am = 128'((a < 0) ? -a : a);
  bm = 128'((b < 0) ? -b : b);
  p = (am * bm + (128'd1 << 27)) >> FRAC_W;
  return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
endfunction

class svf_checker;
  typedef struct {
    logic ch;
    smp_t smp;
  } filtered_t;

  filtered_t due_samples[$];
  logic [MODE_W-1:0] mode;
  longint a1, a2, a3, damp, gain;
  longint ic1[CHANNELS];
  longint ic2[CHANNELS];
  int errors, checked, clipped;

  function new();
    mode = MODE_LP;
    a1 = longint'(A1_RST);
    a2 = 0;
    a3 = 0;
    damp = longint'(K_RST);
    gain = longint'(SHELF_RST);
    foreach (ic1[i]) begin
      ic1[i] = 0;
      ic2[i] = 0;
    end
    errors = 0;
    checked = 0;
    clipped = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, coef_t data);
    case (idx)
      CFG_MODE: mode = data[MODE_W-1:0];
      CFG_A1: a1 = longint'(data);
      CFG_A2: a2 = longint'(data);
      CFG_A3: a3 = longint'(data);
      CFG_K: damp = longint'(data);
      CFG_SHELF: gain = longint'(data);
      default: ;
    endcase
  endfunction

  function smp_t filter_step(logic ch, smp_t x);
    localparam longint UNITY = longint'(1) <<< FRAC_W;
    int idx;
    longint v0, c1, c2, v3, v1, v2, a2sq, y;
    idx = int'(ch) % CHANNELS;
    v0 = longint'(x);
    c1 = ic1[idx];
    c2 = ic2[idx];
    v3 = clip_to(v0 - c2, 32);
    v1 = clip_to(q28_mul(a1, c1) + q28_mul(a2, v3), 32);
    v2 = clip_to(c2 + q28_mul(a2, c1) + q28_mul(a3, v3), 32);
    ic1[idx] = clip_to(2 * v1 - c1, 32);
    ic2[idx] = clip_to(2 * v2 - c2, 32);
    a2sq = q28_mul(gain, gain);
    case (mode)
      MODE_LP: y = v2;
      MODE_BP: y = v1;
      MODE_NOTCH: y = v0 - q28_mul(damp, v1);
      MODE_HP: y = v0 - q28_mul(damp, v1) - v2;
      MODE_AP: y = v0 - q28_mul(2 * damp, v1);
      MODE_PEAK: y = 2 * v2 - v0 + q28_mul(damp, v1);
      MODE_BELL: y = v0 + q28_mul(q28_mul(damp, a2sq - UNITY), v1);
      MODE_LSHELF: begin
        y = v0 + q28_mul(q28_mul(damp, gain - UNITY), v1) + q28_mul(a2sq - UNITY, v2);
      end
      MODE_HSHELF: begin
        y = q28_mul(a2sq, v0) + q28_mul(q28_mul(q28_mul(damp, UNITY - gain), gain), v1)
          + q28_mul(UNITY - a2sq, v2);
      end
      default: y = 0;
    endcase
    return smp_t'(clip_to(y, SAMPLE_W));
  endfunction

  function void note_input(logic ch, smp_t x);
    filtered_t e;
    e.ch = ch;
    e.smp = filter_step(ch, x);
    due_samples.push_back(e);
  endfunction

  function void check_result(logic ch, smp_t y);
    filtered_t e;
    if (due_samples.size() == 0) begin
      $error("unexpected item: channel_out %0d, sample_out %0d", ch, y);
      errors++;
      return;
    end
    e = due_samples.pop_front();
    checked++;
    if (e.smp == smp_t'(24'h7FFFFF) || e.smp == smp_t'(24'h800000)) clipped++;
    if (ch !== e.ch) begin
      $error("channel_out: expected %0d, actual %0d", e.ch, ch);
      errors++;
    end
    if (y !== e.smp) begin
      $error("sample_out: expected %0d, actual %0d", e.smp, y);
      errors++;
    end
  endfunction
endclass

module trapezoidal_state_variable_filter_tb;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES = 14;
  localparam int REG_COUNT = CFG_SHELF + 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_SHELF + 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = {CFG_IDX_W{1'b1}};
  localparam logic [MODE_W-1:0] MODE_TOP = {MODE_W{1'b1}};
  localparam coef_t COEF_MAX = {COEF_W{1'b1}};
  localparam smp_t FULL_POS = smp_t'(24'h7FFFFF);
  localparam smp_t FULL_NEG = smp_t'(24'h800000);

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  svf_in_if in_bus ();
  svf_out_if out_bus ();

  trapezoidal_state_variable_filter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  svf_checker board = new();
  coef_t reg_val[REG_COUNT];
  bit steady_flow;
  bit hold_off_req;
  bit [15:0] modes_seen;
  longint walk[CHANNELS];
  int walk_step;
  int items_sent;
  int settings;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 96) return $urandom_range(5, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic coef_t to_q28(real x);
    real s;
    s = x * 268435456.0;
    if (s >= 2147483647.0) return COEF_MAX;
    if (s <= 0.0) return '0;
    return coef_t'($rtoi(s));
  endfunction

  // Coefficients of a real, stable filter for the given g, damping and shelf gain.
  function automatic void tune(real g, real damping, real amp);
    real c1;
    c1 = 1.0 / (1.0 + g * (g + damping));
    reg_val[CFG_A1] = to_q28(c1);
    reg_val[CFG_A2] = to_q28(g * c1);
    reg_val[CFG_A3] = to_q28(g * g * c1);
    reg_val[CFG_K] = to_q28(damping);
    reg_val[CFG_SHELF] = to_q28(amp);
  endfunction

  function automatic smp_t next_sample(logic ch);
    int r;
    r = $urandom_range(99);
    if (r < 4) return $urandom_range(1) ? FULL_POS : FULL_NEG;
    if (r < 10) return smp_t'($urandom);
    walk[ch] = clip_to(walk[ch] + longint'($urandom_range(0, 2 * walk_step)) - walk_step,
      SAMPLE_W);
    return smp_t'(walk[ch]);
  endfunction

  task automatic program_regs();
    logic [CFG_IDX_W-1:0] spare;
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= reg_val[i];
      board.write_reg(CFG_IDX_W'(i), reg_val[i]);
      @(negedge clk);
    end
    if ($urandom_range(2) == 0) begin
      spare = CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI));
      cfg_we <= 1'b1;
      cfg_index <= spare;
      cfg_wdata <= coef_t'($urandom);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    modes_seen[reg_val[CFG_MODE][MODE_W-1:0]] = 1'b1;
    settings++;
  endtask

  task automatic send_sample(logic ch, smp_t s);
    int gap;
    in_bus.valid <= 1'b1;
    in_bus.channel <= ch;
    in_bus.sample_in <= s;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    board.note_input(ch, s);
    items_sent++;
    @(negedge clk);
    gap = steady_flow ? 0 : pick_idle();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      in_bus.channel <= 1'($urandom_range(1));
      in_bus.sample_in <= smp_t'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (board.due_samples.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      board.check_result(out_bus.channel_out, out_bus.sample_out);
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (steady_flow) begin
          out_bus.ready <= 1'b1;
          stall_left = 0;
        end else if (stall_left > 0) begin
          out_bus.ready <= 1'b0;
          stall_left--;
        end else if ($urandom_range(99) < 72) begin
          out_bus.ready <= 1'b1;
        end else begin
          out_bus.ready <= 1'b0;
          stall_left = pick_idle();
        end
        @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("No completion within %0d cycles.", cycles);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    smp_t edge_samples[5];
    logic ch;
    int n;
    int style;
    logic [MODE_W-1:0] m;
    edge_samples = '{FULL_POS, FULL_NEG, smp_t'(-1), smp_t'(1), smp_t'(0)};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.channel = 1'b0;
    in_bus.sample_in = '0;
    steady_flow = 1'b1;
    hold_off_req = 1'b0;
    modes_seen = '0;
    foreach (walk[i]) walk[i] = 0;
    walk_step = 4096;
    items_sent = 0;
    settings = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (edge_samples[i]) send_sample(1'(i), edge_samples[i]);
    drain();

    // Every mode code once, with a shelf gain away from unity so the shelves do work.
    steady_flow = 1'b0;
    tune(0.35, 0.6, 2.0);
    for (int i = 0; i < (1 << MODE_W); i++) begin
      reg_val[CFG_MODE] = coef_t'({27'($urandom), MODE_W'(i)});
      program_regs();
      send_sample(1'(i), (i % 3 == 2) ? next_sample(1'(i)) : edge_samples[i % 2]);
      drain();
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      style = $urandom_range(9);
      m = MODE_W'($urandom_range(MODE_LP, MODE_HSHELF));
      if (p == 0) begin
        foreach (reg_val[i]) reg_val[i] = COEF_MAX;
      end else if (p == 1) begin
        foreach (reg_val[i]) reg_val[i] = '0;
      end else if (style < 6 || style == 9) begin
        tune($urandom_range(5, 3000) / 1000.0, $urandom_range(50, 2000) / 1000.0,
          $urandom_range(250, 4000) / 1000.0);
        if (style == 9) m = MODE_W'($urandom_range(MODE_HSHELF + 1, MODE_TOP));
      end else if (style < 8) begin
        foreach (reg_val[i]) reg_val[i] = coef_t'($urandom);
      end else begin
        tune($urandom_range(5, 3000) / 1000.0, $urandom_range(50, 2000) / 1000.0,
          $urandom_range(250, 4000) / 1000.0);
        foreach (reg_val[i]) begin
          case ($urandom_range(2))
            0: reg_val[i] = '0;
            1: reg_val[i] = COEF_MAX;
            default: ;
          endcase
        end
      end
      reg_val[CFG_MODE] = coef_t'({27'($urandom), m});
      program_regs();

      steady_flow = (p == 4) || ($urandom_range(6) == 0);
      case ($urandom_range(3))
        0: walk_step = 64;
        1: walk_step = 4096;
        2: walk_step = 262144;
        default: walk_step = 4194304;
      endcase
      if (p == 3) hold_off_req = 1'b1;
      n = $urandom_range(70, 100);
      ch = 1'b0;
      for (int i = 0; i < n; i++) begin
        ch = ($urandom_range(3) != 0) ? ~ch : 1'($urandom_range(1));
        send_sample(ch, next_sample(ch));
        if (p == 6 && i == n / 2) drain();
      end
      drain();
    end

    repeat (80) @(negedge clk);
    $display("Filtered %0d input items under %0d register settings, %0d of 16 mode codes.",
      items_sent, settings, $countones(modes_seen));
    $display("Checked %0d output items, %0d of them clipped at full scale.",
      board.checked, board.clipped);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
